// ===== design/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants for the turntable aim sequencer.
// ----------------------------------------------------------------------------
package tas_pkg;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        aim_angle;
    logic signed [15:0] launch_distance;
    logic [2:0]         target_index;
    logic [1:0]         command_kind;
    logic [2:0]         throw_launcher;
    logic signed [15:0] throw_power;
    logic               unreachable;
  } out_item_t;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_NEXT = 2'd1;
  localparam logic [1:0] ACT_PREV = 2'd2;
  localparam logic [1:0] ACT_RUN  = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_CATCH = 2'd1;
  localparam logic [1:0] CMD_SWING = 2'd2;
  localparam logic [1:0] CMD_THROW = 2'd3;

  localparam int AW = 28;  // angle accumulator, radians * 2^24
  localparam int CW = 56;  // cordic x/y width

  localparam logic signed [AW-1:0] HALF_PI   = 28'sd26353589;
  localparam logic signed [AW-1:0] PI_Q24    = 28'sd52707179;
  localparam logic signed [AW:0]   TWO_PI    = 29'sd105414357;
  localparam logic signed [AW:0]   ANGLE_MAX = 29'sd82208358;
  localparam logic [12:0]          DIST_BIAS = 13'd539;

  // datapath commands
  localparam logic [2:0] DP_IDLE   = 3'd0;
  localparam logic [2:0] DP_PREP   = 3'd1;  // load squares
  localparam logic [2:0] DP_SQRT   = 3'd2;  // one root step
  localparam logic [2:0] DP_CLOAD  = 3'd3;  // load cordic pass
  localparam logic [2:0] DP_CSTEP  = 3'd4;  // one cordic step
  localparam logic [2:0] DP_FINISH = 3'd5;  // form outputs

  typedef struct packed {
    logic [2:0] op;
    logic       pass;   // 0: target pass, 1: offset pass
    logic [4:0] idx;    // cordic iteration
  } dp_cmd_t;

  typedef struct packed {
    logic unreach;
  } dp_sts_t;

  function automatic logic [AW-1:0] atan_entry(input logic [4:0] i);
    logic [AW-1:0] v;
    begin
      case (i)
        5'd0:  v = 28'd13176795;
        5'd1:  v = 28'd7778716;
        5'd2:  v = 28'd4110060;
        5'd3:  v = 28'd2086331;
        5'd4:  v = 28'd1047214;
        5'd5:  v = 28'd524117;
        5'd6:  v = 28'd262123;
        5'd7:  v = 28'd131069;
        5'd8:  v = 28'd65536;
        5'd9:  v = 28'd32768;
        5'd10: v = 28'd16384;
        5'd11: v = 28'd8192;
        5'd12: v = 28'd4096;
        5'd13: v = 28'd2048;
        5'd14: v = 28'd1024;
        5'd15: v = 28'd512;
        5'd16: v = 28'd256;
        5'd17: v = 28'd128;
        5'd18: v = 28'd64;
        5'd19: v = 28'd32;
        5'd20: v = 28'd16;
        5'd21: v = 28'd8;
        5'd22: v = 28'd4;
        5'd23: v = 28'd2;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== design/tas_datapath.sv =====
// ----------------------------------------------------------------------------
// tas_datapath
// Squares, bit-serial square root, shared CORDIC vectoring unit and output
// formatting for one tick.
// ----------------------------------------------------------------------------
module tas_datapath (
  input  logic                 clk,
  input  tas_pkg::dp_cmd_t     cmd,
  input  logic signed [15:0]   x_in,
  input  logic signed [15:0]   y_in,
  input  logic signed [12:0]   off_in,
  output tas_pkg::dp_sts_t     sts,
  output logic [15:0]          angle_out,
  output logic signed [15:0]   dist_out
);

  localparam int CW = tas_pkg::CW;
  localparam int AW = tas_pkg::AW;

  logic [47:0]           rem_r, rem_nxt;     // (d2-off2)<<16, shifted out two bits a step
  logic [23:0]           acc_r, acc_nxt;     // partial remainder
  logic [23:0]           root_r, root_nxt;
  logic                  unr_r, unr_nxt;
  logic signed [CW-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [AW-1:0]  cz_r, cz_nxt, za_r, za_nxt;
  logic [15:0]           ang_r, ang_nxt;
  logic signed [15:0]    dist_r, dist_nxt;

  logic signed [32:0] d2;
  logic signed [25:0] off2;
  logic signed [CW-1:0] lx, ly, sx, sy;
  logic [25:0] acc_sh, trial;
  logic signed [AW:0] ang;
  logic [25:0] rnd;
  logic signed [26:0] dist_w;

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    root_nxt = root_r;
    unr_nxt  = unr_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cz_nxt   = cz_r;
    za_nxt   = za_r;
    ang_nxt  = ang_r;
    dist_nxt = dist_r;
    d2   = 33'(x_in * x_in) + 33'(y_in * y_in);
    off2 = 26'(off_in * off_in);
    lx = '0;
    ly = '0;
    sx = cx_r >>> cmd.idx;
    sy = cy_r >>> cmd.idx;
    acc_sh = {acc_r, rem_r[47:46]};
    trial  = {root_r, 2'b01};
    ang = '0;
    rnd = '0;
    dist_w = '0;
    unique case (cmd.op)
      tas_pkg::DP_PREP: begin
        // check reach and seed the root
        unr_nxt  = (d2 <= 33'(off2));
        rem_nxt  = 48'({(d2 - 33'(off2)), 16'd0});
        acc_nxt  = '0;
        root_nxt = '0;
      end
      tas_pkg::DP_SQRT: begin
        // one restoring root digit, top pair of bits first
        if (acc_sh >= trial) begin
          acc_nxt  = 24'(acc_sh - trial);
          root_nxt = {root_r[22:0], 1'b1};
        end else begin
          acc_nxt  = 24'(acc_sh);
          root_nxt = {root_r[22:0], 1'b0};
        end
        rem_nxt = rem_r << 2;
      end
      tas_pkg::DP_CLOAD: begin
        // load a vectoring pass with quadrant pre-rotation
        // target pass: atan2(x, -y); offset pass: atan2(off*256, r)
        if (!cmd.pass) begin
          lx = -(CW'(y_in) <<< 16);
          ly = CW'(x_in) <<< 16;
        end else begin
          lx = CW'($signed({1'b0, root_r})) <<< 16;
          ly = CW'(off_in) <<< 24;
        end
        cz_nxt = '0;
        if (lx < 0) begin
          cz_nxt = (ly >= 0) ? tas_pkg::PI_Q24 : -tas_pkg::PI_Q24;
          cx_nxt = -lx;
          cy_nxt = -ly;
        end else begin
          cx_nxt = lx;
          cy_nxt = ly;
        end
      end
      tas_pkg::DP_CSTEP: begin
        // one micro-rotation
        if (cy_r > 0) begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          cz_nxt = cz_r + AW'(tas_pkg::atan_entry(cmd.idx));
        end else begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          cz_nxt = cz_r - AW'(tas_pkg::atan_entry(cmd.idx));
        end
      end
      tas_pkg::DP_FINISH: begin
        // target pass: keep its angle; offset pass: combine angles, wrap, clamp, round; form distance
        if (!cmd.pass) begin
          za_nxt = cz_r;
        end else begin
          ang = (AW+1)'(tas_pkg::HALF_PI) + (AW+1)'(za_r) - (AW+1)'(cz_r);
          if (ang < 0) ang = ang + tas_pkg::TWO_PI;
          if (ang > tas_pkg::ANGLE_MAX) ang = tas_pkg::ANGLE_MAX;
          ang_nxt = 16'((ang + 29'sd1024) >>> 11);
          rnd = (26'(root_r) + 26'd128) >> 8;
          dist_w = $signed({9'd0, rnd[17:0]}) - $signed({14'd0, tas_pkg::DIST_BIAS});
          if (dist_w > 27'sd32767) dist_nxt = 16'sh7fff;
          else if (dist_w < -27'sd32768) dist_nxt = -16'sd32768;
          else dist_nxt = 16'(dist_w);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    root_r <= root_nxt;
    unr_r  <= unr_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    za_r   <= za_nxt;
    ang_r  <= ang_nxt;
    dist_r <= dist_nxt;
  end

  assign sts.unreach   = unr_r;
  assign angle_out     = ang_r;
  assign dist_out      = dist_r;

endmodule

// ===== design/tas_control.sv =====
// ----------------------------------------------------------------------------
// tas_control
// Sequencer state machine: handshake, target and throw sequencing, and
// stepping of the datapath through a tick.
// ----------------------------------------------------------------------------
module tas_control #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tas_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tas_pkg::out_item_t  out_data,
  output tas_pkg::dp_cmd_t    cmd,
  input  tas_pkg::dp_sts_t    sts,
  input  logic [15:0]         angle_dp,
  input  logic signed [15:0]  dist_dp,
  output logic [2:0]          launcher
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_CORD  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       pass_r, pass_nxt;
  logic [2:0] sel_r, sel_nxt, step_r, step_nxt, lau_r, lau_nxt;
  logic [15:0] ang_r, ang_nxt;
  logic signed [15:0] dist_r, dist_nxt;
  logic        ov_r, ov_nxt;
  tas_pkg::out_item_t od_r, od_nxt;
  logic accept;

  assign in_stall  = (state_r != ST_IDLE) || (ov_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign launcher  = lau_r;

  always_comb begin
    cmd.op   = tas_pkg::DP_IDLE;
    cmd.pass = pass_r;
    cmd.idx  = cnt_r;
    unique case (state_r)
      ST_PREP: cmd.op = tas_pkg::DP_PREP;
      ST_SQRT: cmd.op = tas_pkg::DP_SQRT;
      ST_LOAD: cmd.op = tas_pkg::DP_CLOAD;
      ST_CORD: cmd.op = tas_pkg::DP_CSTEP;
      ST_FIN:  cmd.op = tas_pkg::DP_FINISH;
      default: cmd.op = tas_pkg::DP_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    lau_nxt   = lau_r;
    ang_nxt   = ang_r;
    dist_nxt  = dist_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          od_nxt = '0;
          od_nxt.aim_angle       = ang_r;
          od_nxt.launch_distance = dist_r;
          case (in_data.action)
            tas_pkg::ACT_TICK: begin
              if (sel_r == 3'd0) begin
                ang_nxt = '0;
                dist_nxt = '0;
                od_nxt.aim_angle = '0;
                od_nxt.launch_distance = '0;
                od_nxt.target_index = sel_r;
                ov_nxt = 1'b1;
              end else begin
                state_nxt = ST_PREP;
              end
            end
            tas_pkg::ACT_NEXT: begin
              sel_nxt = (sel_r >= 3'd5) ? 3'd0 : sel_r + 3'd1;
              od_nxt.target_index = sel_nxt;
              ov_nxt = 1'b1;
            end
            tas_pkg::ACT_PREV: begin
              sel_nxt = (sel_r == 3'd0) ? 3'd5 : sel_r - 3'd1;
              od_nxt.target_index = sel_nxt;
              ov_nxt = 1'b1;
            end
            default: begin
              od_nxt.target_index = sel_r;
              if (step_r == 3'd0) od_nxt.command_kind = tas_pkg::CMD_CATCH;
              else if (step_r == 3'd1) od_nxt.command_kind = tas_pkg::CMD_SWING;
              else begin
                od_nxt.command_kind   = tas_pkg::CMD_THROW;
                od_nxt.throw_launcher = lau_r;
                od_nxt.throw_power    = dist_r;
                lau_nxt = lau_r + 3'd1;
              end
              if (step_r == 3'd6) begin
                step_nxt = 3'd0;
                lau_nxt  = 3'd1;
              end else begin
                step_nxt = step_r + 3'd1;
              end
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_PREP: begin
        cnt_nxt = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        // 24 root steps, the last one at count 23
        if (sts.unreach) begin
          od_nxt.unreachable = 1'b1;
          od_nxt.target_index = sel_r;
          state_nxt = ST_EMIT;
        end else if (cnt_r == 5'd23) begin
          pass_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end else cnt_nxt = cnt_r + 5'd1;
      end
      ST_LOAD: begin
        cnt_nxt = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        if (cnt_r == 5'(NSTEP - 1)) state_nxt = ST_FIN;
        else cnt_nxt = cnt_r + 5'd1;
      end
      ST_FIN: begin
        if (!pass_r) begin
          pass_nxt = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          od_nxt.target_index = sel_r;
          state_nxt = ST_EMIT;
          pass_nxt = 1'b0;
          cnt_nxt = 5'd1;
        end
      end
      ST_EMIT: begin
        // latch datapath results in the cycle after finish
        if (!od_r.unreachable) begin
          ang_nxt = angle_dp;
          dist_nxt = dist_dp;
          od_nxt.aim_angle = angle_dp;
          od_nxt.launch_distance = dist_dp;
        end
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pass_r  <= 1'b0;
      sel_r   <= '0;
      step_r  <= '0;
      lau_r   <= 3'd1;
      ang_r   <= '0;
      dist_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
      lau_r   <= lau_nxt;
      ang_r   <= ang_nxt;
      dist_r  <= dist_nxt;
      ov_r    <= ov_nxt;
    end
    od_r <= od_nxt;
  end

endmodule

// ===== design/turntable_aim_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// turntable_aim_sequencer_unit
// Aims a launcher table at a target and sequences catch, swing and throws.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | tas_pkg::in_item_t
//   out_    | output    | out_valid/out_stall | tas_pkg::out_item_t
//   cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// Non-tick items and ticks with no target give their result in the cycle after
// acceptance and can follow every cycle while the output is not stalled. A
// reachable tick runs the 24-step square root and then the shared CORDIC unit
// twice, target pass then offset pass; an unreachable tick ends at the first
// root step. The input stalls meanwhile. Reset (rst_n, synchronous) clears
// the sequencer state and offsets. A stalled result holds the input side off.
// ----------------------------------------------------------------------------
module turntable_aim_sequencer_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tas_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tas_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  logic signed [12:0] off_r [5];
  logic signed [12:0] off_sel;
  logic [2:0] launcher;
  tas_pkg::dp_cmd_t cmd;
  tas_pkg::dp_sts_t sts;
  logic [15:0] angle_dp;
  logic signed [15:0] dist_dp;
  tas_pkg::in_item_t in_data_q;

  // write offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) off_r[i] <= '0;
    end else if (cfg_we && cfg_index < 3'd5) begin
      off_r[cfg_index] <= cfg_data;
    end
  end

  // pick the active launcher's offset
  always_comb begin
    case (launcher)
      3'd1: off_sel = off_r[0];
      3'd2: off_sel = off_r[1];
      3'd3: off_sel = off_r[2];
      3'd4: off_sel = off_r[3];
      3'd5: off_sel = off_r[4];
      default: off_sel = '0;
    endcase
  end

  tas_control #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cmd, .sts, .angle_dp, .dist_dp, .launcher
  );

  tas_datapath u_dp (
    .clk, .cmd, .x_in(in_data_q.target_x), .y_in(in_data_q.target_y),
    .off_in(off_sel), .sts, .angle_out(angle_dp), .dist_out(dist_dp)
  );

  // hold the tick position for the duration of the computation
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_q <= in_data;
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall) else $error("accept under stalled result");
  a_launch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.command_kind == tas_pkg::CMD_THROW |->
      out_data.throw_launcher != 3'd0) else $error("throw without launcher");
  a_idx_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.target_index <= 3'd5) else $error("target index range");
`endif

endmodule

// ===== tb/tb_turntable_aim_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turntable_aim_sequencer_unit
// Self-checking bench: a queue-fed request driver, a result monitor and a
// bit-exact aiming and sequencing predictor, run over several offset settings.
// ----------------------------------------------------------------------------
module tb_turntable_aim_sequencer_unit;

  localparam int N_STEPS = 16;
  localparam int LAT     = 120;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  tas_pkg::in_item_t  in_data;
  logic       out_valid;
  logic       out_stall;
  tas_pkg::out_item_t out_data;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [12:0] cfg_data;

  turntable_aim_sequencer_unit #(.CORDIC_STEPS(N_STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [12:0] offs [1:5];
  logic [2:0]  sel_target;
  logic [2:0]  seq_step;
  logic [2:0]  act_launcher;
  logic [15:0] hold_angle;
  logic signed [15:0] hold_dist;

  tas_pkg::in_item_t  request_q [$];
  tas_pkg::out_item_t expected_q [$];
  int  send_idle_pct, recv_idle_pct;
  bit  long_hold;
  int  n_fail, n_checked, n_unreach, n_throw;
  longint atan_tab [0:23];
  logic in_stall_s;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor shift for signed values
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_angle(longint ya, longint xa);
    longint x, y, z, nx, ny;
    x = xa * 65536;
    y = ya * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + sra(y, i); ny = y - sra(x, i); z += atan_tab[i];
      end else begin
        nx = x - sra(y, i); ny = y + sra(x, i); z -= atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // compute the expected result of one request and advance the state
  function automatic tas_pkg::out_item_t aim_and_sequence(tas_pkg::in_item_t it);
    tas_pkg::out_item_t r;
    longint x, y, off, d2, off2, ang, dst;
    longint unsigned rt;
    r = '0;
    r.unreachable = 1'b0;
    case (it.action)
      tas_pkg::ACT_TICK: begin
        if (sel_target == 0) begin
          hold_angle = 0;
          hold_dist = 0;
        end else begin
          x = it.target_x;
          y = it.target_y;
          off = (act_launcher >= 1 && act_launcher <= 5) ? longint'(offs[act_launcher]) : 0;
          d2 = x * x + y * y;
          off2 = off * off;
          if (d2 <= off2) begin
            r.unreachable = 1'b1;
          end else begin
            rt = root_floor(longint'(d2 - off2) << 16);
            ang = 64'sd26353589 + cordic_angle(x, -y) - cordic_angle(off * 256, longint'(rt));
            if (ang < 0) ang += 64'sd105414357;
            if (ang > 64'sd82208358) ang = 64'sd82208358;
            hold_angle = 16'((ang + 1024) >>> 11);
            dst = longint'((rt + 128) >> 8) - 539;
            if (dst > 32767) dst = 32767;
            if (dst < -32768) dst = -32768;
            hold_dist = 16'(dst);
          end
        end
      end
      tas_pkg::ACT_NEXT: sel_target = (sel_target >= 5) ? 3'd0 : sel_target + 3'd1;
      tas_pkg::ACT_PREV: sel_target = (sel_target == 0) ? 3'd5 : sel_target - 3'd1;
      default: begin
        if (seq_step == 0) begin
          r.command_kind = tas_pkg::CMD_CATCH;
        end else if (seq_step == 1) begin
          r.command_kind = tas_pkg::CMD_SWING;
        end else begin
          r.command_kind = tas_pkg::CMD_THROW;
          r.throw_launcher = act_launcher;
          r.throw_power = hold_dist;
          act_launcher = act_launcher + 3'd1;
        end
        if (seq_step == 6) begin
          seq_step = 0;
          act_launcher = 3'd1;
        end else begin
          seq_step = seq_step + 3'd1;
        end
      end
    endcase
    r.aim_angle = hold_angle;
    r.launch_distance = hold_dist;
    r.target_index = sel_target;
    return r;
  endfunction

  // driver: present queued requests, hold while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_s) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accept and predict at the rising edge
  always @(posedge clk) begin
    in_stall_s <= in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_q.push_back(aim_and_sequence(in_data));
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    tas_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (out_data.unreachable) n_unreach++;
        if (out_data.command_kind == tas_pkg::CMD_THROW) n_throw++;
        if (out_data.aim_angle !== e.aim_angle) begin
          $error("aim_angle exp %0d got %0d", e.aim_angle, out_data.aim_angle); n_fail++;
        end
        if (out_data.launch_distance !== e.launch_distance) begin
          $error("launch_distance exp %0d got %0d", e.launch_distance,
                 out_data.launch_distance); n_fail++;
        end
        if (out_data.target_index !== e.target_index) begin
          $error("target_index exp %0d got %0d", e.target_index, out_data.target_index);
          n_fail++;
        end
        if (out_data.command_kind !== e.command_kind) begin
          $error("command_kind exp %0d got %0d", e.command_kind, out_data.command_kind);
          n_fail++;
        end
        if (out_data.throw_launcher !== e.throw_launcher) begin
          $error("throw_launcher exp %0d got %0d", e.throw_launcher,
                 out_data.throw_launcher); n_fail++;
        end
        if (out_data.throw_power !== e.throw_power) begin
          $error("throw_power exp %0d got %0d", e.throw_power, out_data.throw_power);
          n_fail++;
        end
        if (out_data.unreachable !== e.unreachable) begin
          $error("unreachable exp %0d got %0d", e.unreachable, out_data.unreachable);
          n_fail++;
        end
      end
    end
  end

  function automatic tas_pkg::in_item_t mk(logic [1:0] a, logic [15:0] x, logic [15:0] y);
    tas_pkg::in_item_t it;
    it.action = a;
    it.target_x = x;
    it.target_y = y;
    return it;
  endfunction

  // random request: half ticks; positions half at modest range, the rest full range or near zero
  function automatic tas_pkg::in_item_t rand_request();
    int k;
    logic [15:0] x, y;
    k = $urandom_range(99);
    case ($urandom_range(3))
      0: begin x = 16'($urandom); y = 16'($urandom); end
      1: begin x = 16'($signed($urandom_range(200)) - 100);
               y = 16'($signed($urandom_range(200)) - 100); end
      default: begin x = 16'($signed($urandom_range(16000)) - 8000);
                     y = 16'($signed($urandom_range(16000)) - 8000); end
    endcase
    if (k < 50) return mk(tas_pkg::ACT_TICK, x, y);
    if (k < 62) return mk(tas_pkg::ACT_NEXT, x, y);
    if (k < 72) return mk(tas_pkg::ACT_PREV, x, y);
    return mk(tas_pkg::ACT_RUN, x, y);
  endfunction

  task automatic wait_drained();
    while (request_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_offset(logic [2:0] idx, logic [12:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    offs[idx + 1] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_offsets(int mode);
    for (int i = 0; i < 5; i++) begin
      case (mode)
        0: write_offset(3'(i), 13'h1000);
        1: write_offset(3'(i), 13'h0FFF);
        2: write_offset(3'(i), 13'd0);
        default: write_offset(3'(i), 13'($urandom));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) atan_tab[i] = longint'(tas_pkg::atan_entry(5'(i)));
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 15;
    recv_idle_pct = 54;
    long_hold = 1'b0;
    n_fail = 0; n_checked = 0; n_unreach = 0; n_throw = 0;
    for (int i = 1; i <= 5; i++) offs[i] = '0;
    sel_target = 0; seq_step = 0; act_launcher = 1; hold_angle = 0; hold_dist = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: no target, centre with zero offset, extremes, wrap of target index
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'h7FFF, 16'h8000));
    request_q.push_back(mk(tas_pkg::ACT_PREV, 16'd0, 16'd0));
    request_q.push_back(mk(tas_pkg::ACT_NEXT, 16'd0, 16'd0));
    request_q.push_back(mk(tas_pkg::ACT_NEXT, 16'd0, 16'd0));
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'd0, 16'd0));
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'h8000, 16'h8000));
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'h7FFF, 16'h7FFF));
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'h8000, 16'h0000));
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'h0000, 16'h7FFF));
    request_q.push_back(mk(tas_pkg::ACT_TICK, 16'h0001, 16'hFFFF));
    for (int i = 0; i < 8; i++) request_q.push_back(mk(tas_pkg::ACT_RUN, 16'd0, 16'd0));
    for (int i = 0; i < 5; i++) request_q.push_back(mk(tas_pkg::ACT_NEXT, 16'd0, 16'd0));
    wait_drained();

    // sweep offset settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      set_offsets(ph);
      if (ph == 2) begin send_idle_pct = 54; recv_idle_pct = 15; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      request_q.push_back(mk(tas_pkg::ACT_TICK, 16'd100, 16'd50));
      request_q.push_back(mk(tas_pkg::ACT_TICK, 16'hFFF0, 16'd8));
      for (int i = 0; i < 200; i++) request_q.push_back(rand_request());
      if (ph == 1) begin
        // hold the receiver off so the block backs up
        long_hold = 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_drained();
    end

    $display("checked %0d results, %0d unreachable, %0d throws, six offset settings",
             n_checked, n_unreach, n_throw);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
design/tas_pkg.sv
design/tas_datapath.sv
design/tas_control.sv
design/turntable_aim_sequencer_unit.sv
tb/tb_turntable_aim_sequencer_unit.sv
